// ===== hdl/dpws_pkg.sv =====
// types, constants and helper functions for the daily port window scheduler
// no dependencies; imported by every module of the block but dpws_ram
package dpws_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int NUM_PORTS   = 7;

    localparam int ADDR_W   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W    = $clog2(MAX_ENTRIES + 1);
    localparam int PORT_W   = 3;
    localparam int HOUR_W   = 5;
    localparam int MIN_W    = 6;
    localparam int SEC_W    = 6;
    localparam int TIME_W   = 17;
    localparam int LEVEL_W  = 7;

    localparam int SEC_PER_MIN  = 60;
    localparam int MIN_PER_HOUR = 60;
    localparam int MAX_HOUR     = 24;
    localparam int SEC_PER_HOUR = SEC_PER_MIN * MIN_PER_HOUR;

    localparam logic [LEVEL_W-1:0] ALL_PORTS =
        (NUM_PORTS >= LEVEL_W) ? {LEVEL_W{1'b1}} :
        LEVEL_W'((64'd1 << NUM_PORTS) - 64'd1);

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_FULL     = 2'd1,
        STATUS_BAD_PORT = 2'd2,
        STATUS_BAD_TIME = 2'd3
    } status_t;

    typedef struct packed {
        logic              command;
        logic [PORT_W-1:0] port;
        logic [HOUR_W-1:0] start_hour;
        logic [MIN_W-1:0]  start_minute;
        logic [SEC_W-1:0]  start_second;
        logic [HOUR_W-1:0] end_hour;
        logic [MIN_W-1:0]  end_minute;
        logic [SEC_W-1:0]  end_second;
        logic [TIME_W-1:0] now_seconds;
    } in_item_t;

    typedef struct packed {
        status_t            status;
        logic [LEVEL_W-1:0] port_levels;
        logic [LEVEL_W-1:0] changed_mask;
    } out_item_t;

    typedef struct packed {
        logic [PORT_W-1:0] port;
        logic [TIME_W-1:0] start_sec;
        logic [TIME_W-1:0] end_sec;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    function automatic logic time_ok(
        input logic [HOUR_W-1:0] h,
        input logic [MIN_W-1:0]  m,
        input logic [SEC_W-1:0]  s
    );
        return (int'(h) <= MAX_HOUR) && (int'(m) < MIN_PER_HOUR) &&
               (int'(s) < SEC_PER_MIN);
    endfunction

    function automatic logic [TIME_W-1:0] to_seconds(
        input logic [HOUR_W-1:0] h,
        input logic [MIN_W-1:0]  m,
        input logic [SEC_W-1:0]  s
    );
        return TIME_W'(h) * TIME_W'(SEC_PER_HOUR) + TIME_W'(m) * TIME_W'(SEC_PER_MIN)
               + TIME_W'(s);
    endfunction

    function automatic logic covers(
        input entry_t            e,
        input logic [TIME_W-1:0] now
    );
        logic after_start;
        logic before_end;
        after_start = (now >= e.start_sec);
        before_end  = (now < e.end_sec);
        if (e.start_sec <= e.end_sec)
        begin
            return after_start && before_end;
        end
        return after_start || before_end;
    endfunction

endpackage

// ===== hdl/daily_port_window_scheduler_core.sv =====
// a load result is registered in the sequencer and then in the output register;
// a tick result follows a walk of the whole table and passes through the same registers
// the sequencer takes no new item until its last result has moved to the output register;
// a walk reads one table entry per cycle on the single read port
// reset: table empty, all ports on, output empty; the table needs no clearing
module daily_port_window_scheduler_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  dpws_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output dpws_pkg::out_item_t out_item
);
    import dpws_pkg::*;

    logic                res_valid;
    out_item_t           res_item;
    logic                res_take;
    logic                ram_wr_en;
    logic [ADDR_W-1:0]   ram_wr_addr;
    logic [ENTRY_W-1:0]  ram_wr_data;
    logic                ram_rd_en;
    logic [ADDR_W-1:0]   ram_rd_addr;
    logic [ENTRY_W-1:0]  ram_rd_data;
    logic                out_valid_reg;
    out_item_t           out_item_reg;

    dpws_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_item     (in_item),
        .res_valid   (res_valid),
        .res_item    (res_item),
        .res_take    (res_take),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data)
    );

    dpws_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // output register frees the sequencer while a result waits
    assign res_take  = res_valid && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_item_reg  <= '0;
        end
        else if (res_take)
        begin
            out_valid_reg <= 1'b1;
            out_item_reg  <= res_item;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

endmodule

// ===== hdl/dpws_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module dpws_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]      wr_data,
    input  logic                  rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hdl/dpws_ctrl.sv =====
// command sequencer: checks and stores loads, walks the window table on ticks
// depends on dpws_pkg; drives the ports of the window table ram
module dpws_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  dpws_pkg::in_item_t            in_item,
    output logic                          res_valid,
    output dpws_pkg::out_item_t           res_item,
    input  logic                          res_take,
    output logic                          ram_wr_en,
    output logic [dpws_pkg::ADDR_W-1:0]   ram_wr_addr,
    output logic [dpws_pkg::ENTRY_W-1:0]  ram_wr_data,
    output logic                          ram_rd_en,
    output logic [dpws_pkg::ADDR_W-1:0]   ram_rd_addr,
    input  logic [dpws_pkg::ENTRY_W-1:0]  ram_rd_data
);
    import dpws_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DONE
    } state_t;

    state_t             state_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic [CNT_W-1:0]   idx_reg;
    logic               rd_vld_reg;
    logic [TIME_W-1:0]  now_reg;
    logic [LEVEL_W-1:0] owned_reg;
    logic [LEVEL_W-1:0] on_reg;
    out_item_t          res_reg;

    logic               accept;
    status_t            load_status;
    entry_t             new_entry;
    entry_t             rd_entry;
    logic [LEVEL_W-1:0] port_bit;
    logic [LEVEL_W-1:0] level_next;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res_item  = res_reg;

    always_comb
    begin
        if (int'(in_item.port) >= NUM_PORTS)
        begin
            load_status = STATUS_BAD_PORT;
        end
        else if (!time_ok(in_item.start_hour, in_item.start_minute, in_item.start_second)
                 || !time_ok(in_item.end_hour, in_item.end_minute, in_item.end_second))
        begin
            load_status = STATUS_BAD_TIME;
        end
        else if (count_reg >= CNT_W'(MAX_ENTRIES))
        begin
            load_status = STATUS_FULL;
        end
        else
        begin
            load_status = STATUS_OK;
        end
    end

    always_comb
    begin
        new_entry.port      = in_item.port;
        new_entry.start_sec = to_seconds(in_item.start_hour, in_item.start_minute,
                                         in_item.start_second);
        new_entry.end_sec   = to_seconds(in_item.end_hour, in_item.end_minute,
                                         in_item.end_second);
    end

    assign ram_wr_en   = accept && (in_item.command == CMD_LOAD) && (load_status == STATUS_OK);
    assign ram_wr_addr = count_reg[ADDR_W-1:0];
    assign ram_wr_data = new_entry;

    assign ram_rd_en   = (state_reg == S_WALK) && (idx_reg < count_reg);
    assign ram_rd_addr = idx_reg[ADDR_W-1:0];

    assign rd_entry   = entry_t'(ram_rd_data);
    assign port_bit   = LEVEL_W'(8'd1 << rd_entry.port);
    assign level_next = (level_reg & ~owned_reg) | (on_reg & owned_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            level_reg  <= ALL_PORTS;
            idx_reg    <= '0;
            rd_vld_reg <= 1'b0;
            now_reg    <= '0;
            owned_reg  <= '0;
            on_reg     <= '0;
            res_reg    <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (in_item.command == CMD_LOAD)
                        begin
                            if (load_status == STATUS_OK)
                            begin
                                count_reg <= count_reg + CNT_W'(1);
                            end
                            res_reg.status       <= load_status;
                            res_reg.port_levels  <= level_reg;
                            res_reg.changed_mask <= '0;
                            state_reg            <= S_DONE;
                        end
                        else
                        begin
                            now_reg    <= in_item.now_seconds;
                            idx_reg    <= '0;
                            rd_vld_reg <= 1'b0;
                            owned_reg  <= '0;
                            on_reg     <= '0;
                            state_reg  <= S_WALK;
                        end
                    end
                end
                S_WALK:
                begin
                    rd_vld_reg <= ram_rd_en;
                    if (ram_rd_en)
                    begin
                        idx_reg <= idx_reg + CNT_W'(1);
                    end
                    if (rd_vld_reg)
                    begin
                        owned_reg <= owned_reg | port_bit;
                        if (covers(rd_entry, now_reg))
                        begin
                            on_reg <= on_reg | port_bit;
                        end
                    end
                    else if (!ram_rd_en)
                    begin
                        level_reg            <= level_next;
                        res_reg.status       <= STATUS_OK;
                        res_reg.port_levels  <= level_next;
                        res_reg.changed_mask <= level_next ^ level_reg;
                        state_reg            <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (res_take)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== hdl/dpws_checker.sv =====
// port-level checks for daily_port_window_scheduler_core, attached by bind
// depends on dpws_pkg
module dpws_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_stall,
    input dpws_pkg::out_item_t out_item
);
    import dpws_pkg::*;

    logic [LEVEL_W-1:0] last_levels_reg;

    // levels as last delivered, starting from all on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_levels_reg <= ALL_PORTS;
        end
        else if (out_valid && !out_stall)
        begin
            last_levels_reg <= out_item.port_levels;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("stalled output item changed");

    a_levels_chain: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_item.port_levels ^ out_item.changed_mask) == last_levels_reg)
        else $error("port levels do not follow from previous item and changed mask");

    a_change_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_item.changed_mask != '0) |-> out_item.status == STATUS_OK)
        else $error("level change reported with error status");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("output valid after reset");

endmodule

bind daily_port_window_scheduler_core dpws_checker u_dpws_checker (.*);

// ===== tb/sv/testbench.sv =====
// self-checking testbench for daily_port_window_scheduler_core
// drives load and tick items under random idling and checks every result item
// against a local schedule model; depends on dpws_pkg and the core rtl only
module testbench;
    import dpws_pkg::*;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    in_item_t  in_item = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_item_t out_item;

    in_item_t  queued_commands[$];
    out_item_t pending_reports[$];
    entry_t    windows[$];
    logic [LEVEL_W-1:0] levels = ALL_PORTS;

    int unsigned window_edges[$];
    int          total_items = 0;
    int          accepted_count = 0;
    int          mismatch_count = 0;
    logic [1:0]  phase = 2'd0;
    int          hold_left = 0;
    logic        pressure_done = 1'b0;

    daily_port_window_scheduler_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    function automatic logic hms_valid(input int h, input int m, input int s);
        return h <= MAX_HOUR && m < MIN_PER_HOUR && s < SEC_PER_MIN;
    endfunction

    function automatic int hms_seconds(input int h, input int m, input int s);
        return (h * MIN_PER_HOUR + m) * SEC_PER_MIN + s;
    endfunction

    // updates the schedule state and returns the report an item should produce
    function automatic out_item_t next_port_report(input in_item_t cmd);
        out_item_t          rep;
        entry_t             win;
        logic [LEVEL_W-1:0] owned;
        logic [LEVEL_W-1:0] lit;
        logic [LEVEL_W-1:0] updated;
        logic               hit;
        rep.status = STATUS_OK;
        rep.changed_mask = '0;
        if (cmd.command == CMD_LOAD)
        begin
            if (int'(cmd.port) >= NUM_PORTS)
            begin
                rep.status = STATUS_BAD_PORT;
            end
            else if (!hms_valid(int'(cmd.start_hour), int'(cmd.start_minute),
                                int'(cmd.start_second)) ||
                     !hms_valid(int'(cmd.end_hour), int'(cmd.end_minute),
                                int'(cmd.end_second)))
            begin
                rep.status = STATUS_BAD_TIME;
            end
            else if (windows.size() >= MAX_ENTRIES)
            begin
                rep.status = STATUS_FULL;
            end
            else
            begin
                win.port      = cmd.port;
                win.start_sec = TIME_W'(hms_seconds(int'(cmd.start_hour),
                                                    int'(cmd.start_minute),
                                                    int'(cmd.start_second)));
                win.end_sec   = TIME_W'(hms_seconds(int'(cmd.end_hour),
                                                    int'(cmd.end_minute),
                                                    int'(cmd.end_second)));
                windows.push_back(win);
            end
        end
        else
        begin
            owned = '0;
            lit = '0;
            foreach (windows[i])
            begin
                if (windows[i].start_sec <= windows[i].end_sec)
                begin
                    hit = cmd.now_seconds >= windows[i].start_sec &&
                          cmd.now_seconds < windows[i].end_sec;
                end
                else
                begin
                    hit = cmd.now_seconds >= windows[i].start_sec ||
                          cmd.now_seconds < windows[i].end_sec;
                end
                owned[windows[i].port] = 1'b1;
                if (hit)
                begin
                    lit[windows[i].port] = 1'b1;
                end
            end
            owned = owned & ALL_PORTS;
            updated = (levels & ~owned) | (lit & owned);
            rep.changed_mask = updated ^ levels;
            levels = updated;
        end
        rep.port_levels = levels;
        return rep;
    endfunction

    // unused fields carry random noise
    function automatic in_item_t load_cmd(input int p, input int sh, input int sm,
                                          input int ss, input int eh, input int em,
                                          input int es);
        in_item_t c;
        c = $bits(in_item_t)'({$urandom, $urandom});
        c.command      = CMD_LOAD;
        c.port         = PORT_W'(p);
        c.start_hour   = HOUR_W'(sh);
        c.start_minute = MIN_W'(sm);
        c.start_second = SEC_W'(ss);
        c.end_hour     = HOUR_W'(eh);
        c.end_minute   = MIN_W'(em);
        c.end_second   = SEC_W'(es);
        return c;
    endfunction

    function automatic in_item_t tick_cmd(input int unsigned now);
        in_item_t c;
        c = $bits(in_item_t)'({$urandom, $urandom});
        c.command     = CMD_TICK;
        c.now_seconds = TIME_W'(now);
        return c;
    endfunction

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20000000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        int p;
        int sh;
        int sm;
        int ss;
        int eh;
        int em;
        int es;
        int edge_sec;
        int roll;

        queued_commands.push_back(tick_cmd(0));
        queued_commands.push_back(load_cmd(0, 8, 0, 0, 17, 30, 0));
        queued_commands.push_back(tick_cmd(28799));
        queued_commands.push_back(tick_cmd(28800));
        queued_commands.push_back(tick_cmd(63000));
        // wraps over midnight
        queued_commands.push_back(load_cmd(1, 22, 0, 0, 6, 0, 0));
        queued_commands.push_back(tick_cmd(82800));
        queued_commands.push_back(tick_cmd(21599));
        queued_commands.push_back(tick_cmd(21600));
        // empty window
        queued_commands.push_back(load_cmd(2, 12, 0, 0, 12, 0, 0));
        queued_commands.push_back(tick_cmd(43200));
        // one port split at midnight, windows must be ored
        queued_commands.push_back(load_cmd(3, 20, 0, 0, 24, 0, 0));
        queued_commands.push_back(load_cmd(3, 0, 0, 0, 2, 0, 0));
        queued_commands.push_back(tick_cmd(3600));
        queued_commands.push_back(tick_cmd(86399));
        queued_commands.push_back(tick_cmd(10800));
        // hour 24 on both ends
        queued_commands.push_back(load_cmd(6, 24, 0, 0, 24, 59, 59));
        queued_commands.push_back(load_cmd(5, 10, 0, 0, 24, 0, 0));
        queued_commands.push_back(tick_cmd(86400));
        queued_commands.push_back(tick_cmd(131071));
        // bad port takes priority over bad time
        queued_commands.push_back(load_cmd(7, 31, 63, 63, 31, 63, 63));
        queued_commands.push_back(load_cmd(4, 25, 0, 0, 1, 0, 0));
        queued_commands.push_back(load_cmd(4, 1, 0, 0, 2, 60, 0));
        queued_commands.push_back(load_cmd(4, 1, 0, 63, 2, 0, 0));
        queued_commands.push_back(tick_cmd(89999));

        for (int n = 0; n < 600; n++)
        begin
            if ($urandom_range(99) < 20)
            begin
                p  = $urandom_range(NUM_PORTS - 1);
                sh = $urandom_range(MAX_HOUR);
                sm = $urandom_range(59);
                ss = $urandom_range(59);
                eh = $urandom_range(MAX_HOUR);
                em = $urandom_range(59);
                es = $urandom_range(59);
                roll = $urandom_range(99);
                if (roll < 80)
                begin
                    window_edges.push_back(hms_seconds(sh, sm, ss));
                    window_edges.push_back(hms_seconds(eh, em, es));
                end
                else if (roll < 90)
                begin
                    p  = 7;
                    sh = $urandom_range(31);
                    sm = $urandom_range(63);
                    ss = $urandom_range(63);
                end
                else
                begin
                    case ($urandom_range(5))
                        0: sh = $urandom_range(31, 25);
                        1: sm = $urandom_range(63, 60);
                        2: ss = $urandom_range(63, 60);
                        3: eh = $urandom_range(31, 25);
                        4: em = $urandom_range(63, 60);
                        default: es = $urandom_range(63, 60);
                    endcase
                end
                queued_commands.push_back(load_cmd(p, sh, sm, ss, eh, em, es));
            end
            else
            begin
                roll = $urandom_range(99);
                if (roll < 50 && window_edges.size() != 0)
                begin
                    edge_sec = window_edges[$urandom_range(window_edges.size() - 1)];
                    edge_sec = edge_sec + $urandom_range(2) - 1;
                    if (edge_sec < 0)
                    begin
                        edge_sec = 0;
                    end
                    queued_commands.push_back(tick_cmd(edge_sec));
                end
                else if (roll < 90)
                begin
                    queued_commands.push_back(tick_cmd($urandom_range(86399)));
                end
                else
                begin
                    queued_commands.push_back(tick_cmd($urandom_range(131071)));
                end
            end
        end
        total_items = queued_commands.size();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted_count != total_items) @(posedge clk);
        while (pending_reports.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (mismatch_count == 0 && pending_reports.size() == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // driver
    always @(posedge clk)
    begin
        int idle_pct;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                pending_reports.push_back(next_port_report(in_item));
                accepted_count++;
                phase <= (accepted_count * 3 / total_items > 2) ? 2'd2
                         : 2'(accepted_count * 3 / total_items);
            end
            if (!in_valid || !in_stall)
            begin
                idle_pct = (phase == 2'd0) ? 32 : (phase == 2'd1) ? 78 : 0;
                if (queued_commands.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    in_item  <= queued_commands.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off once the last phase begins
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (phase == 2'd2 && !pressure_done)
            begin
                hold_left     <= 300;
                pressure_done <= 1'b1;
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        out_item_t want;
        int        stall_pct;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_reports.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("unexpected result item: status %0d levels %b changed %b",
                                 out_item.status, out_item.port_levels,
                                 out_item.changed_mask);
                    end
                end
                else
                begin
                    want = pending_reports.pop_front();
                    if (out_item.status !== want.status ||
                        out_item.port_levels !== want.port_levels ||
                        out_item.changed_mask !== want.changed_mask)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $display("mismatch: want %0d %b %b, got %0d %b %b",
                                     want.status, want.port_levels, want.changed_mask,
                                     out_item.status, out_item.port_levels,
                                     out_item.changed_mask);
                        end
                    end
                end
            end
            stall_pct = (phase == 2'd0) ? 78 : (phase == 2'd1) ? 32 : 0;
            out_stall <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
        end
    end

endmodule

// ===== filelist.f =====
hdl/dpws_pkg.sv
hdl/dpws_ram.sv
hdl/dpws_ctrl.sv
hdl/daily_port_window_scheduler_core.sv
hdl/dpws_checker.sv
tb/sv/testbench.sv
